FILE: src/spf_pkg.sv
// Shared types and constants for the smallest-prime-factor sieve factorizer.
// Used by every module of the block; depends on nothing.
package spf_pkg;

  // values at or above this limit are answered as having no factor
  localparam int unsigned VALUE_LIMIT = 65536;
  // a 16-bit value never needs more table entries than this
  localparam int unsigned TABLE_DEPTH = 65536;
  localparam int unsigned TABLE_SPAN  = (VALUE_LIMIT < TABLE_DEPTH) ? VALUE_LIMIT : TABLE_DEPTH;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned DATA_W  = 16;
  // sieve primes stop below sqrt(span) <= 256, so nine bits hold up to 256
  localparam int unsigned OUTER_W = 9;
  localparam int unsigned SQ_W    = 2 * OUTER_W;
  // multiples may step one prime past the top of the table
  localparam int unsigned INNER_W = ADDR_W + 1;
  localparam int unsigned DIV_CNT_W = $clog2(VALUE_W);

  // table port request
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } spf_ram_req_t;

  // table build sequencer
  typedef enum logic [2:0] {
    BUILD_FILL,
    BUILD_OUTER_RD,
    BUILD_OUTER_CHK,
    BUILD_INNER_RD,
    BUILD_INNER_CHK,
    BUILD_DONE
  } build_state_e;

  // factoring sequencer
  typedef enum logic [1:0] {
    FACT_IDLE,
    FACT_WAIT_P,
    FACT_DIV,
    FACT_CHECK
  } fact_state_e;

endpackage

FILE: src/spf_sieve_prime_factorizer_unit.sv
// Factors a 16-bit value into its distinct primes, smallest first, one result per strobe.
// After reset the block fills the table with identity and then sieves it, reading and then
// checking each multiple visited; busy stays high until done. Each value then needs a first
// table lookup, and for each prime power a division by its prime in the bit-serial divider
// and a lookup of the quotient, before busy drops again. Results come as single-cycle
// valid_o pulses and cannot be held off; the last one for a value has last_o set. Values
// 0, 1 and those outside the table give one result with no_factor_o set, on the cycle
// after the item is taken. Depends on spf_pkg, spf_table_ram, spf_divider, spf_sieve.
module spf_sieve_prime_factorizer_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [spf_pkg::VALUE_W-1:0] value_i,
  output logic                        valid_o,
  output logic [spf_pkg::VALUE_W-1:0] prime_o,
  output logic                        no_factor_o,
  output logic                        last_o
);

  spf_pkg::spf_ram_req_t          ram_req, sieve_req;
  logic [spf_pkg::DATA_W-1:0]     ram_rdata;
  logic                           table_ready;
  logic                           div_start;
  logic                           div_done;
  logic [spf_pkg::VALUE_W-1:0]    div_quotient;

  spf_pkg::fact_state_e           state_q, state_d;
  logic [spf_pkg::VALUE_W-1:0]    rem_q, rem_d;
  logic [spf_pkg::DATA_W-1:0]     p_q, p_d;
  logic                           valid_q, valid_d;
  logic [spf_pkg::VALUE_W-1:0]    prime_q, prime_d;
  logic                           no_factor_q, no_factor_d;
  logic                           last_q, last_d;
  logic [spf_pkg::ADDR_W-1:0]     fact_raddr;
  logic                           accept;
  logic                           special;
  logic                           same_p;
  logic                           rem_one;

  spf_table_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  spf_sieve u_sieve (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rdata_i (ram_rdata),
    .req_o   (sieve_req),
    .ready_o (table_ready)
  );

  spf_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rem_q),
    .divisor_i  (p_q),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  // table port belongs to the builder until the table is ready
  always_comb begin
    ram_req = sieve_req;
    if (table_ready) begin
      ram_req.we    = 1'b0;
      ram_req.raddr = fact_raddr;
    end
  end

  assign busy    = !table_ready || (state_q != spf_pkg::FACT_IDLE);
  assign accept  = start && !busy;
  assign special = (value_i <= spf_pkg::VALUE_W'(1)) ||
                   ({1'b0, value_i} >= (spf_pkg::VALUE_W+1)'(spf_pkg::TABLE_SPAN));
  assign same_p  = ram_rdata == p_q;
  assign rem_one = rem_q == spf_pkg::VALUE_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      spf_pkg::FACT_IDLE: begin
        if (accept && !special) state_d = spf_pkg::FACT_WAIT_P;
      end
      spf_pkg::FACT_WAIT_P: state_d = spf_pkg::FACT_DIV;
      spf_pkg::FACT_DIV: begin
        if (div_done) state_d = spf_pkg::FACT_CHECK;
      end
      spf_pkg::FACT_CHECK: begin
        if (!same_p && rem_one) begin
          state_d = spf_pkg::FACT_IDLE;
        end else begin
          state_d = spf_pkg::FACT_DIV;
        end
      end
      default: state_d = spf_pkg::FACT_IDLE;
    endcase
  end

  // datapath and result outputs
  always_comb begin
    rem_d       = rem_q;
    p_d         = p_q;
    div_start   = 1'b0;
    fact_raddr  = rem_q;
    valid_d     = 1'b0;
    prime_d     = prime_q;
    no_factor_d = no_factor_q;
    last_d      = last_q;
    case (state_q)
      spf_pkg::FACT_IDLE: begin
        fact_raddr = value_i;
        if (accept) begin
          rem_d = value_i;
          if (special) begin
            valid_d     = 1'b1;
            prime_d     = '0;
            no_factor_d = 1'b1;
            last_d      = 1'b1;
          end
        end
      end
      spf_pkg::FACT_WAIT_P: begin
        // smallest prime factor of the value
        p_d       = ram_rdata;
        div_start = 1'b1;
      end
      spf_pkg::FACT_DIV: begin
        if (div_done) begin
          rem_d      = div_quotient;
          fact_raddr = div_quotient;
        end
      end
      spf_pkg::FACT_CHECK: begin
        // same prime again: divide once more, otherwise report it and, unless the rest is one, divide by the next prime
        if (same_p) begin
          div_start = 1'b1;
        end else begin
          valid_d     = 1'b1;
          prime_d     = p_q;
          no_factor_d = 1'b0;
          last_d      = rem_one;
          if (!rem_one) begin
            p_d       = ram_rdata;
            div_start = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spf_pkg::FACT_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q       <= rem_d;
    p_q         <= p_d;
    prime_q     <= prime_d;
    no_factor_q <= no_factor_d;
    last_q      <= last_d;
  end

  assign valid_o     = valid_q;
  assign prime_o     = prime_q;
  assign no_factor_o = no_factor_q;
  assign last_o      = last_q;

  // a value without factors gives exactly one result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && no_factor_o |-> last_o && (prime_o == '0))
    else $error("no-factor result not single");

  // reported primes are at least two
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !no_factor_o |-> prime_o >= spf_pkg::VALUE_W'(2))
    else $error("reported prime below two");

  // no item is taken while the table is being built
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !table_ready |-> busy && (state_q == spf_pkg::FACT_IDLE))
    else $error("factoring active before table ready");

endmodule

FILE: src/spf_table_ram.sv
// Smallest-prime-factor table: one write port, one registered read port.
// Depends on spf_pkg for widths and the request struct.
module spf_table_ram (
  input  logic                      clk_i,
  input  spf_pkg::spf_ram_req_t     req_i,
  output logic [spf_pkg::DATA_W-1:0] rdata_o
);

  logic [spf_pkg::DATA_W-1:0] mem [spf_pkg::TABLE_DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[req_i.raddr];
  end

endmodule

FILE: src/spf_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on spf_pkg for widths. Divisor must hold steady while active.
module spf_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [spf_pkg::VALUE_W-1:0] dividend_i,
  input  logic [spf_pkg::VALUE_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [spf_pkg::VALUE_W-1:0] quotient_o
);

  logic                           active_q, active_d;
  logic                           done_q, done_d;
  logic [spf_pkg::DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [spf_pkg::VALUE_W-1:0]    rem_q, rem_d;
  logic [spf_pkg::VALUE_W-1:0]    quo_q, quo_d;
  logic [spf_pkg::VALUE_W:0]      trial;

  // one shift-subtract step
  always_comb begin
    trial    = {rem_q, quo_q[spf_pkg::VALUE_W-1]} - {1'b0, divisor_i};
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = '0;
      rem_d    = '0;
      quo_d    = dividend_i;
    end else if (active_q) begin
      if (trial[spf_pkg::VALUE_W]) begin
        rem_d = {rem_q[spf_pkg::VALUE_W-2:0], quo_q[spf_pkg::VALUE_W-1]};
        quo_d = {quo_q[spf_pkg::VALUE_W-2:0], 1'b0};
      end else begin
        rem_d = trial[spf_pkg::VALUE_W-1:0];
        quo_d = {quo_q[spf_pkg::VALUE_W-2:0], 1'b1};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == spf_pkg::DIV_CNT_W'(spf_pkg::VALUE_W - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // done follows the last step of a division
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(active_q) && !$past(start_i) |-> done_q)
    else $error("divider finished without done");

endmodule

FILE: src/spf_sieve.sv
// Table builder: identity fill, then the sieve of Eratosthenes.
// Depends on spf_pkg; drives the table port until the table is ready.
module spf_sieve (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [spf_pkg::DATA_W-1:0]  rdata_i,
  output spf_pkg::spf_ram_req_t       req_o,
  output logic                        ready_o
);

  spf_pkg::build_state_e          state_q, state_d;
  logic [spf_pkg::ADDR_W-1:0]     fill_q, fill_d;
  logic [spf_pkg::OUTER_W-1:0]    outer_q, outer_d;
  logic [spf_pkg::INNER_W-1:0]    inner_q, inner_d;
  logic [spf_pkg::SQ_W-1:0]       sq;
  logic                           sq_done;
  logic                           inner_done;
  logic                           outer_prime;
  logic                           inner_unmarked;

  // loop bounds and table compares
  always_comb begin
    sq             = outer_q * outer_q;
    sq_done        = sq >= spf_pkg::SQ_W'(spf_pkg::TABLE_SPAN);
    inner_done     = inner_q >= spf_pkg::INNER_W'(spf_pkg::TABLE_SPAN);
    outer_prime    = rdata_i == spf_pkg::DATA_W'(outer_q);
    inner_unmarked = rdata_i == spf_pkg::DATA_W'(inner_q[spf_pkg::ADDR_W-1:0]);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      spf_pkg::BUILD_FILL: begin
        if (fill_q == {spf_pkg::ADDR_W{1'b1}}) state_d = spf_pkg::BUILD_OUTER_RD;
      end
      spf_pkg::BUILD_OUTER_RD: begin
        state_d = sq_done ? spf_pkg::BUILD_DONE : spf_pkg::BUILD_OUTER_CHK;
      end
      spf_pkg::BUILD_OUTER_CHK: begin
        state_d = outer_prime ? spf_pkg::BUILD_INNER_RD : spf_pkg::BUILD_OUTER_RD;
      end
      spf_pkg::BUILD_INNER_RD: begin
        state_d = inner_done ? spf_pkg::BUILD_OUTER_RD : spf_pkg::BUILD_INNER_CHK;
      end
      spf_pkg::BUILD_INNER_CHK: state_d = spf_pkg::BUILD_INNER_RD;
      spf_pkg::BUILD_DONE:      state_d = spf_pkg::BUILD_DONE;
      default:                  state_d = spf_pkg::BUILD_FILL;
    endcase
  end

  // table port and loop counters
  always_comb begin
    fill_d      = fill_q;
    outer_d     = outer_q;
    inner_d     = inner_q;
    req_o.we    = 1'b0;
    req_o.waddr = fill_q;
    req_o.wdata = spf_pkg::DATA_W'(fill_q);
    req_o.raddr = inner_q[spf_pkg::ADDR_W-1:0];
    case (state_q)
      spf_pkg::BUILD_FILL: begin
        req_o.we = 1'b1;
        fill_d   = fill_q + 1'b1;
      end
      spf_pkg::BUILD_OUTER_RD: begin
        req_o.raddr = spf_pkg::ADDR_W'(outer_q);
      end
      spf_pkg::BUILD_OUTER_CHK: begin
        if (outer_prime) begin
          inner_d = sq[spf_pkg::INNER_W-1:0];
        end else begin
          outer_d = outer_q + 1'b1;
        end
      end
      spf_pkg::BUILD_INNER_RD: begin
        if (inner_done) outer_d = outer_q + 1'b1;
      end
      spf_pkg::BUILD_INNER_CHK: begin
        // mark only multiples that no smaller prime has claimed
        req_o.we    = inner_unmarked;
        req_o.waddr = inner_q[spf_pkg::ADDR_W-1:0];
        req_o.wdata = spf_pkg::DATA_W'(outer_q);
        inner_d     = inner_q + spf_pkg::INNER_W'(outer_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spf_pkg::BUILD_FILL;
      fill_q  <= '0;
      outer_q <= spf_pkg::OUTER_W'(2);
      inner_q <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      outer_q <= outer_d;
      inner_q <= inner_d;
    end
  end

  assign ready_o = state_q == spf_pkg::BUILD_DONE;

  // the table is never written once factoring may use it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_o |-> !req_o.we)
    else $error("table write after build finished");

endmodule
